// ===== hw/rtl/acc_calc_pkg.sv =====
`default_nettype none
package acc_calc_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5,
    OP_CLR = 3'd6,
    OP_NOP = 3'd7
  } op_t;

  localparam int unsigned OP_W = 3;
  localparam int unsigned IO_W = 64;

endpackage
`default_nettype wire

// ===== hw/rtl/acc_calc_mul.sv =====
`default_nettype none
// shift-add multiplier, one operand bit per cycle, low product bits only
module acc_calc_mul
  import acc_calc_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              done,
  output logic [W-1:0]      prod
);
  localparam int unsigned CW = $clog2(W + 1);

  logic         busy_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0] a_r;
  logic [W-1:0] b_r;
  logic [W-1:0] p_r;

  assign prod = p_r;

  // one add per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= a;
        b_r    <= b;
        p_r    <= '0;
      end else if (busy_r) begin
        if (b_r[0]) p_r <= p_r + a_r;
        a_r   <= a_r << 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/acc_calc_div.sv =====
`default_nettype none
// restoring divider on magnitudes, one quotient bit per cycle
module acc_calc_div
  import acc_calc_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              done,
  output logic [W-1:0]      quo,
  output logic [W-1:0]      rem
);
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  r_r;
  logic [W-1:0]  d_r;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign quo   = q_r;
  assign rem   = r_r;
  assign trial = {r_r, q_r[W-1]};
  assign diff  = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= num;
        r_r    <= '0;
        d_r    <= den;
      end else if (busy_r) begin
        if (!diff[W]) begin
          r_r <= diff[W-1:0];
          q_r <= {q_r[W-2:0], 1'b1};
        end else begin
          r_r <= trial[W-1:0];
          q_r <= {q_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/accumulator_calculator_top.sv =====
`default_nettype none
// signed accumulator calculator
// input channel: in_valid/in_stall with in_opcode and in_operand; one
// transaction updates the accumulator with add, subtract, multiply, divide,
// modulo, power, clear or no change.
// output channel: out_valid/out_stall with out_acc_value (new accumulator,
// sign-extended to 64 bits) and out_status (1 when divide or modulo by zero
// was ignored).
// path from input to output handshake: add, sub, clear, no change and
// divide or modulo by zero go from the execute state to the output state;
// multiply, divide and modulo wait on the one-bit-per-cycle multiplier and
// divider, the multiplier being shared with power. power runs one multiply
// on it per set exponent bit and one square per bit below the top set bit;
// a negative or zero exponent goes straight to the output state.
// one transaction at a time: in_stall is high from acceptance until the
// result is taken, so the next transaction can be accepted in the cycle after that.
// reset clears the accumulator to zero, drops out_valid and holds in_stall.
// a stalled result holds on the output port until taken.
module accumulator_calculator_top
  import acc_calc_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [OP_W-1:0]        in_opcode,
  input  wire logic signed [IO_W-1:0] in_operand,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [IO_W-1:0]      out_acc_value,
  output logic                        out_status
);
  localparam int unsigned W = DATA_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL, S_DIV, S_PSQ, S_PMUL, S_OUT
  } state_t;

  state_t       state_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] b_r;
  logic [W-1:0] e_r;
  logic [W-1:0] base_r;
  logic [OP_W-1:0] op_r;
  logic         st_r;
  logic         an_r;
  logic         bn_r;

  logic         mul_start;
  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic         mul_done;
  logic [W-1:0] mul_p;
  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_q;
  logic [W-1:0] div_rm;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;

  assign mag_a = acc_r[W-1] ? -acc_r : acc_r;
  assign mag_b = b_r[W-1] ? -b_r : b_r;

  acc_calc_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  acc_calc_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(mag_a), .den(mag_b),
    .done(div_done), .quo(div_q), .rem(div_rm)
  );

  assign in_stall      = !rst_n || (state_r != S_IDLE);
  assign out_valid     = (state_r == S_OUT);
  assign out_acc_value = IO_W'(signed'(acc_r));
  assign out_status    = st_r;

  // multiplier operand selection
  always_comb begin
    mul_a = acc_r;
    mul_b = b_r;
    if (state_r == S_PSQ) begin
      mul_a = base_r;
      mul_b = base_r;
    end else if (state_r == S_PMUL) begin
      mul_a = acc_r;
      mul_b = base_r;
    end
  end

  logic started_r;
  assign mul_start = !started_r &&
                     (state_r == S_MUL || state_r == S_PSQ || state_r == S_PMUL);
  assign div_start = !started_r && (state_r == S_DIV);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      acc_r     <= '0;
      st_r      <= 1'b0;
      started_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            b_r     <= in_operand[W-1:0];
            st_r    <= 1'b0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          started_r <= 1'b0;
          an_r      <= acc_r[W-1];
          bn_r      <= b_r[W-1];
          state_r   <= S_OUT;
          case (op_t'(op_r))
            OP_ADD: acc_r <= acc_r + b_r;
            OP_SUB: acc_r <= acc_r - b_r;
            OP_MUL: state_r <= S_MUL;
            OP_DIV, OP_MOD: begin
              if (b_r == '0) st_r <= 1'b1;
              else state_r <= S_DIV;
            end
            OP_POW: begin
              base_r <= acc_r;
              e_r    <= b_r;
              acc_r  <= W'(1);
              if (!b_r[W-1] && b_r != '0) state_r <= S_PMUL;
            end
            OP_CLR: acc_r <= '0;
            default: ;
          endcase
          if (op_t'(op_r) == OP_POW && !b_r[W-1] && b_r != '0 && !b_r[0])
            state_r <= S_PSQ;
        end
        S_MUL: begin
          started_r <= 1'b1;
          if (mul_done) begin
            acc_r     <= mul_p;
            started_r <= 1'b0;
            state_r   <= S_OUT;
          end
        end
        S_DIV: begin
          started_r <= 1'b1;
          if (div_done) begin
            started_r <= 1'b0;
            state_r   <= S_OUT;
            if (op_t'(op_r) == OP_DIV) acc_r <= (an_r != bn_r) ? -div_q : div_q;
            else acc_r <= an_r ? -div_rm : div_rm;
          end
        end
        // result times base when the current exponent bit is set
        S_PMUL: begin
          started_r <= 1'b1;
          if (mul_done) begin
            acc_r     <= mul_p;
            started_r <= 1'b0;
            state_r   <= (e_r[W-1:1] == '0) ? S_OUT : S_PSQ;
          end
        end
        // square the base and move to the next exponent bit
        S_PSQ: begin
          started_r <= 1'b1;
          if (mul_done) begin
            base_r    <= mul_p;
            e_r       <= e_r >> 1;
            started_r <= 1'b0;
            state_r   <= e_r[1] ? S_PMUL : S_PSQ;
          end
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sim/accumulator_calculator_top_tb.sv =====
`default_nettype none
module accumulator_calculator_top_tb;
  import acc_calc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_t         op;
    logic [63:0] operand;
    int          gap_pct;
    int          stall_pct;
    bit          drain_first;
    bit          long_hold;
  } calc_item_t;

  typedef struct {
    logic [63:0] acc;
    logic        status;
  } acc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  op_t         in_opcode = OP_NOP;
  logic signed [63:0] in_operand = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [63:0] out_acc_value;
  logic        out_status;

  calc_item_t  pending_items[$];
  acc_result_t expected_results[$];
  logic [63:0] acc_shadow = '0;
  int          errors = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          hold_reqs = 0;
  int          holds_done = 0;
  int          hold_left = 0;

  accumulator_calculator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_operand(in_operand),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_acc_value(out_acc_value), .out_status(out_status)
  );

  always #4 clk = ~clk;

  // wrapping a^e by square and multiply, 1 for exponent not positive
  function automatic logic [63:0] wrap_power(logic [63:0] base, logic [63:0] e);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd1;
    b = base;
    if (e[63] || e == 0) return 64'd1;
    while (e != 0) begin
      if (e[0]) r = r * b;
      b = b * b;
      e = e >> 1;
    end
    return r;
  endfunction

  // updates the accumulator shadow and returns the expected result
  function automatic acc_result_t apply_calc(op_t op, logic [63:0] b);
    acc_result_t res;
    logic [63:0] a;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    a = acc_shadow;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    res.acc = a;
    res.status = 1'b0;
    case (op)
      OP_ADD: res.acc = a + b;
      OP_SUB: res.acc = a - b;
      OP_MUL: res.acc = a * b;
      OP_DIV: begin
        if (b == 0) res.status = 1'b1;
        else begin
          q = ma / mb;
          res.acc = (a[63] != b[63]) ? -q : q;
        end
      end
      OP_MOD: begin
        if (b == 0) res.status = 1'b1;
        else begin
          q = ma % mb;
          res.acc = a[63] ? -q : q;
        end
      end
      OP_POW: res.acc = wrap_power(a, b);
      OP_CLR: res.acc = '0;
      default: ;
    endcase
    acc_shadow = res.acc;
    return res;
  endfunction

  task automatic queue_item(op_t op, logic [63:0] v, int gp, int sp,
                            bit drain = 0, bit hold = 0);
    calc_item_t it;
    it.op = op;
    it.operand = v;
    it.gap_pct = gp;
    it.stall_pct = sp;
    it.drain_first = drain;
    it.long_hold = hold;
    pending_items.push_back(it);
  endtask

  function automatic logic [63:0] rand_operand(op_t op);
    logic [63:0] v;
    int sel;
    v = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (op == OP_POW) begin
      // long exponents are slow, keep them rare
      if (sel == 0) return v;
      if (sel == 1) return -64'($urandom_range(1, 100));
      return 64'($urandom_range(0, 12));
    end
    case (sel)
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4, 5: return 64'($urandom_range(1, 50));
      6: return -64'($urandom_range(1, 50));
      default: return v;
    endcase
  endfunction

  // driver: computes the expectation for each accepted transaction
  always @(posedge clk) begin
    calc_item_t it;
    bit ready_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(apply_calc(in_opcode, in_operand));
      if (!in_valid || !in_stall) begin
        ready_next = pending_items.size() != 0;
        if (ready_next && pending_items[0].drain_first && expected_results.size() != 0)
          ready_next = 0;
        if (ready_next && $urandom_range(0, 99) < pending_items[0].gap_pct)
          ready_next = 0;
        if (ready_next) begin
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          in_opcode <= it.op;
          in_operand <= it.operand;
          gap_pct = it.gap_pct;
          stall_pct = it.stall_pct;
          if (it.long_hold) hold_reqs++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    acc_result_t ex;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result acc=%h status=%b", $time,
                   out_acc_value, out_status);
          errors++;
        end else begin
          ex = expected_results.pop_front();
          if (out_acc_value !== ex.acc) begin
            $display("%0t: acc_value expected %h actual %h", $time, ex.acc, out_acc_value);
            errors++;
          end
          if (out_status !== ex.status) begin
            $display("%0t: status expected %b actual %b", $time, ex.status, out_status);
            errors++;
          end
        end
      end
      if (hold_left == 0 && holds_done < hold_reqs) begin
        holds_done++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // timeout
  initial begin
    #200ms;
    $display("accumulator_calculator_top_tb failed");
    $finish;
  end

  initial begin
    int n_rand;
    int ph;
    op_t op;
    // directed: extremes, every operation, special cases
    queue_item(OP_ADD, 64'h7fff_ffff_ffff_ffff, 0, 0);
    queue_item(OP_ADD, 64'd1, 0, 0);
    queue_item(OP_SUB, 64'h8000_0000_0000_0000, 0, 0);
    queue_item(OP_MUL, 64'h7fff_ffff_ffff_ffff, 0, 0);
    queue_item(OP_DIV, 64'd0, 0, 0);
    queue_item(OP_MOD, 64'd0, 0, 0);
    queue_item(OP_CLR, 64'd5, 0, 0);
    queue_item(OP_ADD, 64'h8000_0000_0000_0000, 0, 0);
    queue_item(OP_DIV, '1, 0, 0);
    queue_item(OP_MOD, '1, 0, 0);
    queue_item(OP_SUB, 64'd7, 0, 0);
    queue_item(OP_DIV, 64'd2, 0, 0);
    queue_item(OP_MOD, -64'd2, 0, 0);
    queue_item(OP_ADD, -64'd3, 0, 0);
    queue_item(OP_POW, 64'd3, 0, 0);
    queue_item(OP_POW, 64'd0, 0, 0);
    queue_item(OP_ADD, 64'd2, 0, 0);
    queue_item(OP_POW, -64'd5, 0, 0);
    queue_item(OP_ADD, 64'd2, 0, 0);
    queue_item(OP_POW, 64'h7fff_ffff_ffff_ffff, 0, 0);
    queue_item(OP_ADD, 64'd3, 0, 0);
    queue_item(OP_POW, 64'd70, 0, 0);
    queue_item(OP_NOP, '1, 0, 0);
    queue_item(OP_MUL, '1, 0, 0, 0, 1);
    queue_item(OP_ADD, 64'd1, 0, 0, 1, 0);
    // random part in four phases
    n_rand = 630;
    for (int i = 0; i < n_rand; i++) begin
      ph = i * 4 / n_rand;
      op = op_t'($urandom_range(0, 7));
      // occasional clear restarts the value from zero
      if ($urandom_range(0, 19) == 0) op = OP_CLR;
      case (ph)
        0: queue_item(op, rand_operand(op), 0, 0);
        1: queue_item(op, rand_operand(op), 50, 0, i % 150 == 0, 0);
        2: queue_item(op, rand_operand(op), 0, 50, 0, i % 200 == 0);
        default: queue_item(op, rand_operand(op), 37, 37);
      endcase
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("accumulator_calculator_top_tb passed");
    end else begin
      $display("accumulator_calculator_top_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
